// File: rtl/core/bfha_pkg.sv
// Shared types, constants and status codes of the best-fit heap allocator.
package bfha_pkg;

  localparam int HEAP_BYTES_DEF   = 8192;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int MAX_BLOCKS_DEF   = 256;

  localparam int SIZE_W = 14;
  localparam int ADDR_W = 13;
  localparam int STAT_W = 3;

  localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STAT_W-1:0] ST_NULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD      = 3'd4;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] release_address;
  } bfha_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] payload_offset;
  } bfha_rsp_t;

endpackage

// File: rtl/core/bfha_ram.sv
// Generic single-port synchronous RAM with registered read.
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/best_fit_heap_allocator.sv
// Top level of the best-fit heap allocator: block table RAM and sequencer.
//
//  channel | ports                          | handshake
//  in      | start, busy, in_req            | accepted when start & !busy
//  out     | out_valid, out_rsp             | one-cycle strobe, no back-pressure
//
// An allocate reads each table entry in turn (read, then evaluate), then decides
// and raises the strobe; an exact match ends the scan early. No new request is
// taken until the strobe is over. A release scans up to its block and, on a
// merge, shifts the later entries down, one read and one write per entry. All
// table accesses go through the single table RAM port.
// Zero-size and null requests answer in the cycle after acceptance; refused
// and bad-address requests answer after the scan.
// Reset clears block count and heap top; table contents need no clearing.
module best_fit_heap_allocator #(
  parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = bfha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bfha_pkg::bfha_req_t in_req,
  output logic                out_valid,
  output bfha_pkg::bfha_rsp_t out_rsp
);
  import bfha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(HEAP_BYTES + 1) + 1;
  localparam int EW = SIZE_W + 1;  // {free, size}

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ARD   = 4'd1;  // allocate scan: wait read
  localparam logic [3:0] S_AEV   = 4'd2;  // allocate scan: evaluate
  localparam logic [3:0] S_RRD   = 4'd3;  // release scan
  localparam logic [3:0] S_REV   = 4'd4;
  localparam logic [3:0] S_NRD   = 4'd5;  // read next neighbor
  localparam logic [3:0] S_NEV   = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;  // read previous neighbor
  localparam logic [3:0] S_PEV   = 4'd8;
  localparam logic [3:0] S_SHRD  = 4'd9;  // shift: read k+1
  localparam logic [3:0] S_SHWR  = 4'd10; // shift: write k
  localparam logic [3:0] S_WRB   = 4'd11; // write back, then respond or read previous
  localparam logic [3:0] S_PREAD = 4'd12; // unused; returns to idle

  localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

  logic [3:0]        st_r, st_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     top_r, top_nxt;
  bfha_req_t         req_r, req_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic              fnd_r, fnd_nxt;
  logic [IW-1:0]     bi_r, bi_nxt;
  logic [AW-1:0]     bs_r, bs_nxt;   // best start
  logic [SIZE_W:0]   bz_r, bz_nxt;   // best or merged size
  logic [SIZE_W:0]   nsz_r, nsz_nxt; // size merged with previous neighbor
  logic [1:0]        ph_r, ph_nxt;   // 0 after-next, 1 after-prev
  logic              ov_r, ov_nxt;
  bfha_rsp_t         rsp_r, rsp_nxt;

  logic              we;
  logic [IW-1:0]     ra;
  logic [EW-1:0]     wd, rd;

  bfha_ram #(.WIDTH(EW), .DEPTH(1 << IW)) u_tab (
    .clk(clk), .we(we), .addr(ra), .wdata(wd), .rdata(rd)
  );

  logic              rfree;
  logic [SIZE_W-1:0] rsz;
  logic [AW-1:0]     end_pos;
  assign rfree   = rd[EW-1];
  assign rsz     = rd[SIZE_W-1:0];
  assign end_pos = top_r + HDR + AW'(req_r.request_size);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; top_nxt = top_r; req_nxt = req_r;
    i_nxt = i_r; pos_nxt = pos_r; fnd_nxt = fnd_r; bi_nxt = bi_r;
    bs_nxt = bs_r; bz_nxt = bz_r; nsz_nxt = nsz_r; ph_nxt = ph_r;
    ov_nxt = 1'b0; rsp_nxt = rsp_r;
    we = 1'b0; ra = i_r[IW-1:0]; wd = '0;
    unique case (st_r)
      S_IDLE: begin
        // hold off while the last result is on the strobe
        if (start && !ov_r) begin
          req_nxt = in_req; i_nxt = '0; pos_nxt = '0; fnd_nxt = 1'b0;
          ra = '0;
          if (in_req.kind == KIND_ALLOC) begin
            if (in_req.request_size == '0) begin
              rsp_nxt = '{ST_REFUSED, '0}; ov_nxt = 1'b1;
            end else st_nxt = (cnt_r == '0) ? S_AEV : S_ARD;
          end else begin
            if (in_req.release_address == '0) begin
              rsp_nxt = '{ST_NULL, '0}; ov_nxt = 1'b1;
            end else st_nxt = (cnt_r == '0) ? S_REV : S_RRD;
          end
        end
      end
      S_ARD: st_nxt = S_AEV;
      S_AEV: begin
        if (i_r == cnt_r) begin
          if (fnd_r) begin
            we = 1'b1; ra = bi_r; wd = {1'b0, bz_r[SIZE_W-1:0]};
            rsp_nxt = '{ST_GRANTED, ADDR_W'(bs_r + HDR)}; ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end else if (cnt_r == CW'(MAX_BLOCKS) ||
                       end_pos > AW'(HEAP_BYTES)) begin
            rsp_nxt = '{ST_REFUSED, '0}; ov_nxt = 1'b1; st_nxt = S_IDLE;
          end else begin
            we = 1'b1; ra = cnt_r[IW-1:0]; wd = {1'b0, req_r.request_size};
            cnt_nxt = cnt_r + 1'b1; top_nxt = end_pos;
            rsp_nxt = '{ST_GRANTED, ADDR_W'(top_r + HDR)}; ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          if (rfree && rsz >= req_r.request_size &&
              (!fnd_r || {1'b0, rsz} < bz_r)) begin
            fnd_nxt = 1'b1; bi_nxt = i_r[IW-1:0]; bs_nxt = pos_r;
            bz_nxt = {1'b0, rsz};
          end
          if (rfree && rsz == req_r.request_size &&
              (!fnd_r || {1'b0, rsz} < bz_r)) begin
            i_nxt = cnt_r; st_nxt = S_AEV;
          end else begin
            i_nxt = i_r + 1'b1; pos_nxt = pos_r + HDR + AW'(rsz);
            ra = IW'(i_r + 1'b1);
            st_nxt = (i_r + 1'b1 == cnt_r) ? S_AEV : S_ARD;
          end
        end
      end
      S_RRD: st_nxt = S_REV;
      S_REV: begin
        if (i_r == cnt_r) begin
          rsp_nxt = '{ST_BAD, '0}; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (pos_r + HDR == AW'(req_r.release_address)) begin
          bi_nxt = i_r[IW-1:0]; bz_nxt = {1'b0, rsz};
          if (i_r + 1'b1 < cnt_r) begin
            ra = IW'(i_r + 1'b1); st_nxt = S_NRD;
          end else begin
            ph_nxt = 2'd0; st_nxt = S_WRB;
          end
        end else begin
          i_nxt = i_r + 1'b1; pos_nxt = pos_r + HDR + AW'(rsz);
          ra = IW'(i_r + 1'b1); st_nxt = S_RRD;
        end
      end
      S_NRD: begin ra = IW'(bi_r + 1'b1); st_nxt = S_NEV; end
      S_NEV: begin
        if (rfree) begin
          bz_nxt = bz_r + {1'b0, rsz} + (SIZE_W+1)'(HEADER_BYTES);
          i_nxt = CW'(bi_r) + 2'd1; st_nxt = S_SHRD; ph_nxt = 2'd0;
          we = 1'b1; ra = bi_r; wd = {1'b1, bz_nxt[SIZE_W-1:0]};
        end else begin
          ph_nxt = 2'd0; st_nxt = S_WRB;
        end
      end
      // shift entries i+1.. down to i, then drop last
      S_SHRD: begin
        if (i_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          ph_nxt = ph_r; st_nxt = S_WRB;
        end else begin
          ra = IW'(i_r + 1'b1); st_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1; ra = i_r[IW-1:0]; wd = rd;
        i_nxt = i_r + 1'b1; st_nxt = S_SHRD;
      end
      S_WRB: begin
        if (ph_r == 2'd0) begin
          we = 1'b1; ra = bi_r; wd = {1'b1, bz_r[SIZE_W-1:0]};
          if (bi_r != '0) begin
            st_nxt = S_PRD;
          end else begin
            rsp_nxt = '{ST_RELEASED, '0}; ov_nxt = 1'b1; st_nxt = S_IDLE;
          end
        end else begin
          rsp_nxt = '{ST_RELEASED, '0}; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_PRD: begin ra = bi_r - 1'b1; st_nxt = S_PEV; end
      S_PEV: begin
        if (rfree) begin
          nsz_nxt = {1'b0, rsz} + bz_r + (SIZE_W+1)'(HEADER_BYTES);
          we = 1'b1; ra = bi_r - 1'b1; wd = {1'b1, nsz_nxt[SIZE_W-1:0]};
          i_nxt = CW'(bi_r); ph_nxt = 2'd1; st_nxt = S_SHRD;
        end else begin
          rsp_nxt = '{ST_RELEASED, '0}; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_PREAD: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; top_r <= '0; ov_r <= 1'b0; ph_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; top_r <= top_nxt; ov_r <= ov_nxt;
      ph_r <= ph_nxt;
    end
    req_r <= req_nxt; i_r <= i_nxt; pos_r <= pos_nxt; fnd_r <= fnd_nxt;
    bi_r <= bi_nxt; bs_r <= bs_nxt; bz_r <= bz_nxt; nsz_r <= nsz_nxt;
    rsp_r <= rsp_nxt;
  end

  assign busy      = (st_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_rsp   = rsp_r;
endmodule

// File: rtl/core/bfha_checker.sv
// Port-level checker for the best-fit heap allocator, bound to the top level.
module bfha_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input bfha_pkg::bfha_rsp_t out_rsp
);
  import bfha_pkg::*;

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.status <= ST_BAD) else $error("bad status");
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_GRANTED |-> out_rsp.payload_offset == '0)
    else $error("offset on non-grant");
endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_rsp(out_rsp)
);

// File: sim/best_fit_heap_allocator_test.sv
// Self-checking testbench of the best-fit heap allocator, with its own heap table model.
module best_fit_heap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfha_pkg::*;

  localparam int HEAP_B = HEAP_BYTES_DEF;
  localparam int HDR_B  = HEADER_BYTES_DEF;
  localparam int MAX_B  = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 6000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  bfha_req_t in_req = '0;
  logic      out_valid;
  bfha_rsp_t out_rsp;

  best_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  always #5 clk = ~clk;

  // heap table model
  int unsigned tbl_size [MAX_B];
  bit          tbl_free [MAX_B];
  int unsigned tbl_count;
  int unsigned top_used;

  bfha_rsp_t pending_rsp[$];
  int        error_count;
  int        idle_pct;
  int        cycle_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic drop_slot(input int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
      tbl_size[k] = tbl_size[k + 1];
      tbl_free[k] = tbl_free[k + 1];
    end
    tbl_count--;
  endtask

  function automatic int unsigned slot_addr(input int unsigned idx);
    int unsigned s;
    s = 0;
    for (int unsigned i = 0; i < idx; i++) s += HDR_B + tbl_size[i];
    return s + HDR_B;
  endfunction

  task automatic predict_heap(input bfha_req_t r, output bfha_rsp_t o);
    int unsigned s, bi, bs, bsz, sz, idx;
    bit hit;
    o = '0;
    s = 0; bi = 0; bs = 0; bsz = 0; hit = 0;
    if (r.kind == KIND_ALLOC) begin
      sz = r.request_size;
      if (sz == 0) begin
        o.status = ST_REFUSED; return;
      end
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (tbl_free[i] && tbl_size[i] >= sz && (!hit || tbl_size[i] < bsz)) begin
          bi = i; bs = s; bsz = tbl_size[i]; hit = 1;
          if (tbl_size[i] == sz) break;
        end
        s += HDR_B + tbl_size[i];
      end
      if (hit) begin
        tbl_free[bi] = 0;
        o.status = ST_GRANTED;
        o.payload_offset = ADDR_W'(bs + HDR_B);
      end else if (tbl_count >= MAX_B || top_used + HDR_B + sz > HEAP_B) begin
        o.status = ST_REFUSED;
      end else begin
        tbl_size[tbl_count] = sz;
        tbl_free[tbl_count] = 0;
        tbl_count++;
        o.status = ST_GRANTED;
        o.payload_offset = ADDR_W'(top_used + HDR_B);
        top_used += HDR_B + sz;
      end
    end else begin
      if (r.release_address == 0) begin
        o.status = ST_NULL; return;
      end
      idx = 0;
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (s + HDR_B == r.release_address) begin
          idx = i; hit = 1; break;
        end
        s += HDR_B + tbl_size[i];
      end
      if (!hit) begin
        o.status = ST_BAD; return;
      end
      tbl_free[idx] = 1;
      if (idx + 1 < tbl_count && tbl_free[idx + 1]) begin
        tbl_size[idx] += tbl_size[idx + 1] + HDR_B;
        drop_slot(idx + 1);
      end
      if (idx > 0 && tbl_free[idx - 1]) begin
        tbl_size[idx - 1] += tbl_size[idx] + HDR_B;
        drop_slot(idx);
      end
      o.status = ST_RELEASED;
    end
  endtask

  // drive one request and return at the edge that accepts it
  task automatic send_request(input bfha_req_t r);
    bfha_rsp_t o;
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_heap(r, o);
    pending_rsp.push_back(o);
    start <= 1'b0;
  endtask

  task automatic send_alloc(input int unsigned sz);
    bfha_req_t r;
    r = '0; r.kind = KIND_ALLOC; r.request_size = SIZE_W'(sz);
    r.release_address = ADDR_W'($urandom);
    send_request(r);
  endtask

  task automatic send_release(input int unsigned a);
    bfha_req_t r;
    r = '0; r.kind = KIND_RELEASE; r.release_address = ADDR_W'(a);
    r.request_size = SIZE_W'($urandom);
    send_request(r);
  endtask

  // check each result against the oldest expectation
  always @(posedge clk) begin
    bfha_rsp_t w;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result status", out_rsp.status, -1);
      end else begin
        w = pending_rsp.pop_front();
        if (out_rsp.status !== w.status)
          report_mismatch("status", out_rsp.status, w.status);
        if (out_rsp.payload_offset !== w.payload_offset)
          report_mismatch("payload_offset", out_rsp.payload_offset, w.payload_offset);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain_results();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // fresh heap between tests: release everything that is in use
  task automatic release_all();
    int unsigned i;
    i = 0;
    while (i < tbl_count) begin
      if (!tbl_free[i]) begin
        send_release(slot_addr(i));
        i = 0;
      end else i++;
    end
  endtask

  task automatic test_directed();
    send_alloc(0);
    send_release(0);
    send_release(HDR_B);
    send_alloc(8192);
    send_alloc(16383);
    send_alloc(100);
    send_alloc(50);
    send_alloc(100);
    send_alloc(200);
    send_release(HDR_B);
    send_release(HDR_B);
    send_release(HDR_B + 1);
    send_release(8191);
    send_alloc(100);
    send_release(slot_addr(2));
    send_release(slot_addr(1));
    send_release(slot_addr(0));
    send_alloc(80);
    send_alloc(HEAP_B - top_used - HDR_B);
    send_alloc(1);
    release_all();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < MAX_B; i++) send_alloc(1);
    send_alloc(1);
    send_release(slot_addr(MAX_B - 1));
    send_alloc(2);
    send_alloc(1);
    release_all();
  endtask

  task automatic test_random(input int n, input int pct);
    int unsigned p;
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(99);
      if (p < 45) begin
        if ($urandom_range(9) == 0) send_alloc($urandom_range(16383));
        else if ($urandom_range(3) == 0) send_alloc($urandom_range(8, 1));
        else send_alloc($urandom_range(400, 1));
      end else if (p < 90 && tbl_count != 0) begin
        send_release(slot_addr($urandom_range(tbl_count - 1)));
      end else if (p < 95) begin
        send_release($urandom_range(8191));
      end else begin
        send_release($urandom_range(1) ? 0 : 8191);
      end
      // keep the table shallow most of the time
      if (top_used > HEAP_B - 512 && $urandom_range(3) == 0) release_all();
    end
    release_all();
  endtask

  initial begin
    error_count = 0;
    idle_pct = 0;
    cycle_count = 0;
    tbl_count = 0;
    top_used = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(140, 0);
    test_random(140, 51);
    test_random(140, 51);
    test_random(140, 16);
    drain_results();
    repeat (2000) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
